### hdl/csvt_pkg.sv
// Shared constants and types for the CSV stream tokenizer.
package csvt_pkg;

   // Size constants
   localparam int MAX_BLANKS = 16;
   localparam int ROW_BITS   = 16;
   localparam int COL_BITS   = 10;
   localparam int PAT_BITS   = 16;
   localparam int BLK_BITS   = $clog2(MAX_BLANKS + 1);

   // Result field widths
   localparam int ROW_W  = 16;
   localparam int COL_W  = 10;
   localparam int BCNT_W = 5;

   typedef logic [ROW_BITS-1:0] row_type;
   typedef logic [COL_BITS-1:0] col_type;
   typedef logic [BLK_BITS-1:0] blanks_type;
   typedef logic [PAT_BITS-1:0] pattern_type;

   // Input opcodes
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_UNTERM   = 2'd0;
   localparam logic [1:0] ERR_AFTERQ   = 2'd1;
   localparam logic [1:0] ERR_BLANKS   = 2'd2;
   localparam logic [1:0] ERR_POSITION = 2'd3;

   // Characters
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;

   // One result beat
   typedef struct packed {
      logic [1:0]        kind;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [7:0]        byte_res;
      logic [BCNT_W-1:0] blank_count;
      logic [15:0]       blank_pattern;
      logic [1:0]        error_code;
      logic              last;
   } result_type;

   // What one input beat produces: up to two results
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } step_type;

endpackage

### hdl/csvt_parser.sv
// Tokenizer state and per-byte decode: next state and up to two results.
module csvt_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic               opcode,
   input  logic [7:0]         data,
   output csvt_pkg::step_type step
);

   // Parser modes
   localparam logic [2:0] M_START  = 3'd0;
   localparam logic [2:0] M_PLAIN  = 3'd1;
   localparam logic [2:0] M_QUOTED = 3'd2;
   localparam logic [2:0] M_QSEEN  = 3'd3;
   localparam logic [2:0] M_AFTERQ = 3'd4;
   localparam logic [2:0] M_HALT   = 3'd5;

   logic [2:0]             mode_ff, mode_in;
   logic                   cr_ff, cr_in;
   csvt_pkg::row_type      row_ff, row_in;
   csvt_pkg::col_type      col_ff, col_in;
   csvt_pkg::blanks_type   pb_ff, pb_in;
   csvt_pkg::pattern_type  ptb_ff, ptb_in;

   logic is_blank, is_sep, is_quote, is_comma;
   logic do_sep, overflow;
   logic [1:0] cnt;
   csvt_pkg::result_type r0, r1, rx;

   function automatic csvt_pkg::result_type mk(
      input logic [1:0]            kind,
      input csvt_pkg::row_type     row,
      input csvt_pkg::col_type     col,
      input logic [7:0]            byte_val,
      input csvt_pkg::blanks_type  bc,
      input csvt_pkg::pattern_type pat,
      input logic [1:0]            code
   );
      csvt_pkg::result_type r;
      r.kind          = kind;
      r.row           = csvt_pkg::ROW_W'(row);
      r.col           = csvt_pkg::COL_W'(col);
      r.byte_res      = byte_val;
      r.blank_count   = csvt_pkg::BCNT_W'(bc);
      r.blank_pattern = 16'(pat);
      r.error_code    = code;
      r.last          = 1'b0;
      return r;
   endfunction

   // Character classes
   assign is_blank = (data == csvt_pkg::CH_SPACE) || (data == csvt_pkg::CH_TAB);
   assign is_comma = (data == csvt_pkg::CH_COMMA);
   assign is_sep   = is_comma || (data == csvt_pkg::CH_CR) || (data == csvt_pkg::CH_LF);
   assign is_quote = (data == csvt_pkg::CH_QUOTE);

   // Decode one beat
   always_comb begin
      mode_in  = mode_ff;
      cr_in    = cr_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      pb_in    = pb_ff;
      ptb_in   = ptb_ff;
      r0       = '0;
      r1       = '0;
      cnt      = 2'd0;
      do_sep   = 1'b0;
      overflow = 1'b0;
      rx       = '0;
      if (opcode == csvt_pkg::OP_END) begin
         case (mode_ff)
            M_START: begin
               if (pb_ff != '0) begin
                  r0  = mk(csvt_pkg::KIND_END, row_ff, col_ff, 8'd0, pb_ff, ptb_ff, 2'd0);
                  cnt = 2'd1;
               end
            end
            M_PLAIN, M_QSEEN, M_AFTERQ: begin
               r0  = mk(csvt_pkg::KIND_END, row_ff, col_ff, 8'd0, '0, '0, 2'd0);
               cnt = 2'd1;
            end
            M_QUOTED: begin
               r0  = mk(csvt_pkg::KIND_ERR, row_ff, col_ff, 8'd0, '0, '0,
                        csvt_pkg::ERR_UNTERM);
               cnt = 2'd1;
            end
            default: ;
         endcase
         // finish mark reports the position before clearing
         rx = mk(csvt_pkg::KIND_DONE, row_ff, col_ff, 8'd0, '0, '0, 2'd0);
         if (cnt == 2'd0) r0 = rx;
         else r1 = rx;
         cnt     = cnt + 2'd1;
         mode_in = M_START;
         cr_in   = 1'b0;
         row_in  = '0;
         col_in  = '0;
         pb_in   = '0;
         ptb_in  = '0;
      end else begin
         cr_in = 1'b0;
         case (mode_ff)
            M_START: begin
               if ((data == csvt_pkg::CH_LF) && cr_ff && (pb_ff == '0)) begin
                  // LF of a CR LF pair
               end else if (is_blank) begin
                  if (32'(pb_ff) >= csvt_pkg::MAX_BLANKS) begin
                     r0      = mk(csvt_pkg::KIND_ERR, row_ff, col_ff, 8'd0, '0, '0,
                                  csvt_pkg::ERR_BLANKS);
                     cnt     = 2'd1;
                     mode_in = M_HALT;
                  end else begin
                     if ((data == csvt_pkg::CH_TAB) && (32'(pb_ff) < csvt_pkg::PAT_BITS))
                        ptb_in = ptb_ff | (csvt_pkg::pattern_type'(1) << pb_ff);
                     pb_in = pb_ff + csvt_pkg::blanks_type'(1);
                  end
               end else if (is_quote) begin
                  pb_in   = '0;
                  ptb_in  = '0;
                  mode_in = M_QUOTED;
               end else if (is_sep) begin
                  if (pb_ff != '0) begin
                     r0  = mk(csvt_pkg::KIND_END, row_ff, col_ff, 8'd0, pb_ff, ptb_ff, 2'd0);
                     cnt = 2'd1;
                  end
                  do_sep = 1'b1;
               end else begin
                  r0      = mk(csvt_pkg::KIND_BYTE, row_ff, col_ff, data, pb_ff, ptb_ff, 2'd0);
                  cnt     = 2'd1;
                  pb_in   = '0;
                  ptb_in  = '0;
                  mode_in = M_PLAIN;
               end
            end
            M_PLAIN: begin
               if (is_sep) begin
                  r0     = mk(csvt_pkg::KIND_END, row_ff, col_ff, 8'd0, '0, '0, 2'd0);
                  do_sep = 1'b1;
               end else begin
                  r0 = mk(csvt_pkg::KIND_BYTE, row_ff, col_ff, data, '0, '0, 2'd0);
               end
               cnt = 2'd1;
            end
            M_QUOTED: begin
               if (is_quote) begin
                  mode_in = M_QSEEN;
               end else begin
                  r0  = mk(csvt_pkg::KIND_BYTE, row_ff, col_ff, data, '0, '0, 2'd0);
                  cnt = 2'd1;
               end
            end
            M_QSEEN, M_AFTERQ: begin
               if (is_quote && (mode_ff == M_QSEEN)) begin
                  // doubled quote stands for one quote
                  r0      = mk(csvt_pkg::KIND_BYTE, row_ff, col_ff, data, '0, '0, 2'd0);
                  cnt     = 2'd1;
                  mode_in = M_QUOTED;
               end else if (is_sep) begin
                  r0     = mk(csvt_pkg::KIND_END, row_ff, col_ff, 8'd0, '0, '0, 2'd0);
                  cnt    = 2'd1;
                  do_sep = 1'b1;
               end else if (is_blank) begin
                  mode_in = M_AFTERQ;
               end else begin
                  r0      = mk(csvt_pkg::KIND_ERR, row_ff, col_ff, 8'd0, '0, '0,
                               csvt_pkg::ERR_AFTERQ);
                  cnt     = 2'd1;
                  mode_in = M_HALT;
               end
            end
            default: mode_in = M_HALT;
         endcase

         // Field or record separator: advance position or flag overflow
         if (do_sep) begin
            overflow = is_comma ? (col_ff == '1) : (row_ff == '1);
            if (overflow) begin
               rx = mk(csvt_pkg::KIND_ERR, row_ff, col_ff, 8'd0, '0, '0,
                       csvt_pkg::ERR_POSITION);
               if (cnt == 2'd0) r0 = rx;
               else r1 = rx;
               cnt     = cnt + 2'd1;
               mode_in = M_HALT;
            end else begin
               pb_in   = '0;
               ptb_in  = '0;
               mode_in = M_START;
               if (is_comma) begin
                  col_in = col_ff + csvt_pkg::col_type'(1);
               end else begin
                  row_in = row_ff + csvt_pkg::row_type'(1);
                  col_in = '0;
                  cr_in  = (data == csvt_pkg::CH_CR);
               end
            end
         end
      end
      r0.last    = (cnt == 2'd1);
      r1.last    = (cnt == 2'd2);
      step.count = cnt;
      step.res0  = r0;
      step.res1  = r1;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_START;
         cr_ff   <= 1'b0;
         row_ff  <= '0;
         col_ff  <= '0;
         pb_ff   <= '0;
         ptb_ff  <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         cr_ff   <= cr_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         pb_ff   <= pb_in;
         ptb_ff  <= ptb_in;
      end
   end

endmodule

### hdl/csv_stream_tokenizer_unit.sv
// Top level of the CSV stream tokenizer: input register, parser, two-entry result queue.
//
// Input channel req_*: one beat is a text byte (req_opcode = 0) or end of
// input (req_opcode = 1), taken when req_valid is high and req_stall low.
// Result channel rsp_*: cell bytes, cell ends, errors and the finish mark,
// each tagged with row and col; rsp_last marks the final result of a beat.
// Beats that produce no result (dropped blanks, quotes, LF after CR) leave
// the result channel quiet.
// A taken beat is held in the input register, decoded by the parser and
// written into the result queue, whose head drives rsp_*.
// Throughput: one beat per cycle while each beat yields at most one result
// and rsp_stall is low; a beat with two results puts both in the two-entry
// result queue, which the single result port drains one result at a time.
// When rsp_stall is held, the queue fills and req_stall rises; nothing is
// lost or reordered. Synchronous reset empties the pipeline and returns the
// parser to field start at row 0, col 0. End of input also returns it there.
module csv_stream_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_row,
   output logic [9:0]  rsp_col,
   output logic [7:0]  rsp_byte_res,
   output logic [4:0]  rsp_blank_count,
   output logic [15:0] rsp_blank_pattern,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last
);

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_op_ff;
   logic [7:0]           s1_data_ff;
   logic                 req_take, pop, adv;
   logic [2:0]           room;
   logic [1:0]           cnt_ff, cnt_in, keep;
   csvt_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   csvt_pkg::step_type   step;

   // Parser
   csvt_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (adv),
      .opcode (s1_op_ff),
      .data   (s1_data_ff),
      .step   (step)
   );

   // Flow control
   assign pop       = (cnt_ff != 2'd0) && !rsp_stall;
   assign room      = 3'(2'd2 - cnt_ff) + 3'(pop);
   assign adv       = s1_valid_ff && (3'(step.count) <= room);
   assign req_stall = s1_valid_ff && !adv;
   assign req_take  = req_valid && !req_stall;
   assign s1_valid_in = req_take || (s1_valid_ff && !adv);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_opcode;
         s1_data_ff <= req_data;
      end
   end

   // Result queue: shift out the head, append new results behind survivors
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      keep     = cnt_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         keep     = cnt_ff - 2'd1;
      end
      if (adv) begin
         case (keep)
            2'd0: begin
               slot0_in = step.res0;
               slot1_in = step.res1;
            end
            2'd1: slot1_in = step.res0;
            default: ;
         endcase
      end
      cnt_in = keep + (adv ? step.count : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // Result ports
   assign rsp_valid         = (cnt_ff != 2'd0);
   assign rsp_kind          = slot0_ff.kind;
   assign rsp_row           = slot0_ff.row;
   assign rsp_col           = slot0_ff.col;
   assign rsp_byte_res      = slot0_ff.byte_res;
   assign rsp_blank_count   = slot0_ff.blank_count;
   assign rsp_blank_pattern = slot0_ff.blank_pattern;
   assign rsp_error_code    = slot0_ff.error_code;
   assign rsp_last          = slot0_ff.last;

   // Checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_end_has_done: assert property (@(posedge clock) disable iff (reset)
      (adv && (s1_op_ff == csvt_pkg::OP_END)) |-> (step.count != 2'd0))
      else $error("end of input produced no result");

   a_second_kind: assert property (@(posedge clock) disable iff (reset)
      (adv && (step.count == 2'd2)) |->
         ((step.res1.kind == csvt_pkg::KIND_ERR) || (step.res1.kind == csvt_pkg::KIND_DONE)))
      else $error("second result of a beat is neither error nor finish");

   a_pair_kept: assert property (@(posedge clock) disable iff (reset)
      ((cnt_ff != 2'd0) && !slot0_ff.last) |-> (cnt_ff == 2'd2))
      else $error("head result is not last but its partner is missing");

endmodule

### bench/csv_stream_tokenizer_unit_test.sv
// Self-checking testbench for the CSV stream tokenizer unit.
module csv_stream_tokenizer_unit_test;

   localparam int RANDOM_BEATS_PER_PHASE = 230;
   localparam int REPORT_LIMIT = 10;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   // Channel signals, the driven ones known from time zero
   logic        req_valid  = 1'b0;
   logic        req_stall;
   logic        req_opcode = csvt_pkg::OP_DATA;
   logic [7:0]  req_data   = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall  = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_row;
   logic [9:0]  rsp_col;
   logic [7:0]  rsp_byte_res;
   logic [4:0]  rsp_blank_count;
   logic [15:0] rsp_blank_pattern;
   logic [1:0]  rsp_error_code;
   logic        rsp_last;

   csv_stream_tokenizer_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_row           (rsp_row),
      .rsp_col           (rsp_col),
      .rsp_byte_res      (rsp_byte_res),
      .rsp_blank_count   (rsp_blank_count),
      .rsp_blank_pattern (rsp_blank_pattern),
      .rsp_error_code    (rsp_error_code),
      .rsp_last          (rsp_last)
   );

   // Tokenizer scan state mirrored by the predictor
   typedef enum logic [2:0] {
      AT_FIELD_START, IN_PLAIN, IN_QUOTED, QUOTE_SEEN, AFTER_QUOTE, HALTED
   } scan_mode_type;

   scan_mode_type               scan_mode;
   logic                        scan_after_cr;
   csvt_pkg::row_type           scan_row;
   csvt_pkg::col_type           scan_col;
   logic [csvt_pkg::BCNT_W-1:0] scan_blanks;
   csvt_pkg::pattern_type       scan_tabs;

   csvt_pkg::result_type step_tokens[$];
   csvt_pkg::result_type expected_tokens[$];

   // Directed stimulus table
   typedef struct packed {
      logic                 op;
      logic [7:0]           data;
      logic                 pinned;
      csvt_pkg::result_type want;
   } script_row_type;

   script_row_type       script[$];
   logic                 pin_armed = 1'b0;
   csvt_pkg::result_type pinned_token;

   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int rsp_hold_cycles = 0;
   int beats_sent      = 0;
   int failures        = 0;

   function automatic bit is_blank(input logic [7:0] c);
      return c == csvt_pkg::CH_SPACE || c == csvt_pkg::CH_TAB;
   endfunction

   function automatic bit is_separator(input logic [7:0] c);
      return c == csvt_pkg::CH_COMMA || c == csvt_pkg::CH_CR || c == csvt_pkg::CH_LF;
   endfunction

   function automatic void scan_restart();
      scan_mode     = AT_FIELD_START;
      scan_after_cr = 1'b0;
      scan_row      = '0;
      scan_col      = '0;
      scan_blanks   = '0;
      scan_tabs     = '0;
   endfunction

   function automatic void put_token(input logic [1:0] kind, input logic [7:0] b,
                                     input logic [4:0] bc, input csvt_pkg::pattern_type pat,
                                     input logic [1:0] code);
      csvt_pkg::result_type t;
      t.kind          = kind;
      t.row           = scan_row;
      t.col           = scan_col;
      t.byte_res      = b;
      t.blank_count   = bc;
      t.blank_pattern = pat;
      t.error_code    = code;
      t.last          = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void scan_halt(input logic [1:0] code);
      put_token(csvt_pkg::KIND_ERR, 8'h00, '0, '0, code);
      scan_mode = HALTED;
   endfunction

   // Comma moves to the next field, CR or LF to the next record
   function automatic void scan_separator(input logic [7:0] c);
      if (c == csvt_pkg::CH_COMMA) begin
         if (&scan_col) begin
            scan_halt(csvt_pkg::ERR_POSITION);
         end else begin
            scan_col    = scan_col + 1'b1;
            scan_blanks = '0;
            scan_tabs   = '0;
            scan_mode   = AT_FIELD_START;
         end
      end else if (&scan_row) begin
         scan_halt(csvt_pkg::ERR_POSITION);
      end else begin
         scan_row      = scan_row + 1'b1;
         scan_col      = '0;
         scan_blanks   = '0;
         scan_tabs     = '0;
         scan_mode     = AT_FIELD_START;
         scan_after_cr = (c == csvt_pkg::CH_CR);
      end
   endfunction

   function automatic void scan_data(input logic [7:0] c);
      logic was_cr;
      was_cr = scan_after_cr;
      scan_after_cr = 1'b0;
      case (scan_mode)
         AT_FIELD_START: begin
            // LF completing a CR LF pair is swallowed
            if (c == csvt_pkg::CH_LF && was_cr && scan_blanks == 0) return;
            if (is_blank(c)) begin
               if (scan_blanks >= csvt_pkg::MAX_BLANKS) begin
                  scan_halt(csvt_pkg::ERR_BLANKS);
               end else begin
                  if (c == csvt_pkg::CH_TAB && scan_blanks < csvt_pkg::PAT_BITS)
                     scan_tabs[scan_blanks[3:0]] = 1'b1;
                  scan_blanks = scan_blanks + 1'b1;
               end
            end else if (c == csvt_pkg::CH_QUOTE) begin
               scan_blanks = '0;
               scan_tabs   = '0;
               scan_mode   = IN_QUOTED;
            end else if (is_separator(c)) begin
               if (scan_blanks != 0)
                  put_token(csvt_pkg::KIND_END, 8'h00, scan_blanks, scan_tabs, '0);
               scan_separator(c);
            end else begin
               put_token(csvt_pkg::KIND_BYTE, c, scan_blanks, scan_tabs, '0);
               scan_blanks = '0;
               scan_tabs   = '0;
               scan_mode   = IN_PLAIN;
            end
         end
         IN_PLAIN: begin
            if (is_separator(c)) begin
               put_token(csvt_pkg::KIND_END, 8'h00, '0, '0, '0);
               scan_separator(c);
            end else begin
               put_token(csvt_pkg::KIND_BYTE, c, '0, '0, '0);
            end
         end
         IN_QUOTED: begin
            if (c == csvt_pkg::CH_QUOTE) scan_mode = QUOTE_SEEN;
            else put_token(csvt_pkg::KIND_BYTE, c, '0, '0, '0);
         end
         QUOTE_SEEN, AFTER_QUOTE: begin
            if (c == csvt_pkg::CH_QUOTE && scan_mode == QUOTE_SEEN) begin
               // doubled quote stands for one quote
               put_token(csvt_pkg::KIND_BYTE, c, '0, '0, '0);
               scan_mode = IN_QUOTED;
            end else if (is_separator(c)) begin
               put_token(csvt_pkg::KIND_END, 8'h00, '0, '0, '0);
               scan_separator(c);
            end else if (is_blank(c)) begin
               scan_mode = AFTER_QUOTE;
            end else begin
               scan_halt(csvt_pkg::ERR_AFTERQ);
            end
         end
         default: scan_mode = HALTED;
      endcase
   endfunction

   // End of input closes what is open, reports the position, then restarts
   function automatic void scan_finish();
      case (scan_mode)
         AT_FIELD_START:
            if (scan_blanks != 0)
               put_token(csvt_pkg::KIND_END, 8'h00, scan_blanks, scan_tabs, '0);
         IN_PLAIN, QUOTE_SEEN, AFTER_QUOTE:
            put_token(csvt_pkg::KIND_END, 8'h00, '0, '0, '0);
         IN_QUOTED: put_token(csvt_pkg::KIND_ERR, 8'h00, '0, '0, csvt_pkg::ERR_UNTERM);
         default: ;
      endcase
      put_token(csvt_pkg::KIND_DONE, 8'h00, '0, '0, '0);
      scan_restart();
   endfunction

   function automatic string token_text(input csvt_pkg::result_type t);
      return $sformatf(
         "kind=%0d row=%0d col=%0d byte=%02h blanks=%0d pattern=%04h code=%0d last=%0d",
         t.kind, t.row, t.col, t.byte_res, t.blank_count, t.blank_pattern,
         t.error_code, t.last);
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endfunction

   // Table rows: plain rows rely on the predictor, pinned rows carry their result
   function automatic void script_beat(input logic op, input logic [7:0] d);
      script_row_type r;
      r = '0;
      r.op   = op;
      r.data = d;
      script.push_back(r);
   endfunction

   function automatic void script_pinned(input logic op, input logic [7:0] d,
                                         input logic [1:0] kind, input csvt_pkg::row_type row,
                                         input csvt_pkg::col_type col, input logic [7:0] b,
                                         input logic [4:0] bc,
                                         input csvt_pkg::pattern_type pat,
                                         input logic [1:0] code);
      script_row_type r;
      r = '0;
      r.op                 = op;
      r.data               = d;
      r.pinned             = 1'b1;
      r.want.kind          = kind;
      r.want.row           = row;
      r.want.col           = col;
      r.want.byte_res      = b;
      r.want.blank_count   = bc;
      r.want.blank_pattern = pat;
      r.want.error_code    = code;
      r.want.last          = 1'b1;
      script.push_back(r);
   endfunction

   // Byte pickers for random text
   function automatic logic [7:0] pick_blank();
      return ($urandom_range(1) != 0) ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE;
   endfunction

   function automatic logic [7:0] pick_noise();
      case ($urandom_range(11))
         0: return csvt_pkg::CH_COMMA;
         1: return csvt_pkg::CH_CR;
         2: return csvt_pkg::CH_LF;
         3: return csvt_pkg::CH_QUOTE;
         4: return csvt_pkg::CH_SPACE;
         5: return csvt_pkg::CH_TAB;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] pick_text();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (is_separator(c) || is_blank(c) || c == csvt_pkg::CH_QUOTE);
      return c;
   endfunction

   // Offer one beat, wait for it to be taken, then predict its results
   task automatic send_beat(input logic op, input logic [7:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_data   <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      step_tokens.delete();
      if (op == csvt_pkg::OP_END) scan_finish();
      else scan_data(d);
      if (pin_armed) begin
         expected_tokens.push_back(pinned_token);
         pin_armed = 1'b0;
      end else begin
         foreach (step_tokens[i]) begin
            csvt_pkg::result_type t;
            t = step_tokens[i];
            t.last = (i == step_tokens.size() - 1);
            expected_tokens.push_back(t);
         end
      end
   endtask

   // Sender pauses until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (expected_tokens.size() != 0);
   endtask

   // One field of random shape, mostly well formed
   task automatic send_field();
      int shape;
      int n;
      logic [7:0] c;
      shape = $urandom_range(19);
      if (shape < 2) begin
         // empty unquoted field
      end else if (shape < 4) begin
         // blank-only cell, up to the full blank run
         n = $urandom_range(1, csvt_pkg::MAX_BLANKS);
         repeat (n) send_beat(csvt_pkg::OP_DATA, pick_blank());
      end else if (shape < 10) begin
         // unquoted cell with kept leading blanks
         n = ($urandom_range(7) == 0) ? csvt_pkg::MAX_BLANKS : $urandom_range(3);
         repeat (n) send_beat(csvt_pkg::OP_DATA, pick_blank());
         send_beat(csvt_pkg::OP_DATA, pick_text());
         repeat ($urandom_range(6)) begin
            c = pick_noise();
            if (is_separator(c)) c = pick_text();
            send_beat(csvt_pkg::OP_DATA, c);
         end
      end else if (shape < 17) begin
         // quoted cell, blanks around it dropped
         repeat ($urandom_range(2)) send_beat(csvt_pkg::OP_DATA, pick_blank());
         send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
         repeat ($urandom_range(6)) begin
            c = pick_noise();
            send_beat(csvt_pkg::OP_DATA, c);
            if (c == csvt_pkg::CH_QUOTE) send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
         end
         send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
         repeat ($urandom_range(2)) send_beat(csvt_pkg::OP_DATA, pick_blank());
      end else begin
         case ($urandom_range(3))
            0: repeat (csvt_pkg::MAX_BLANKS + 1) send_beat(csvt_pkg::OP_DATA, pick_blank());
            1: begin
               send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
               send_beat(csvt_pkg::OP_DATA, pick_text());
               send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
               send_beat(csvt_pkg::OP_DATA, pick_text());
            end
            2: repeat ($urandom_range(1, 8)) send_beat(csvt_pkg::OP_DATA, pick_noise());
            default: begin
               send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
               repeat ($urandom_range(4)) send_beat(csvt_pkg::OP_DATA, pick_noise());
            end
         endcase
      end
   endtask

   // A short file: a few records, then end of input
   task automatic send_file();
      int records;
      int fields;
      records = $urandom_range(1, 4);
      for (int r = 0; r < records; r++) begin
         fields = $urandom_range(1, 5);
         for (int f = 0; f < fields; f++) begin
            send_field();
            if (f != fields - 1) send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_COMMA);
         end
         case ($urandom_range(3))
            0: begin
               send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_CR);
               send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_LF);
            end
            1: send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_CR);
            2: send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_LF);
            default: if (r != records - 1) send_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_LF);
         endcase
      end
      send_beat(csvt_pkg::OP_END, 8'($urandom_range(255)));
   endtask

   // Receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Result checker: each taken beat against the oldest expectation
   always @(posedge clock) begin : check_results
      csvt_pkg::result_type seen;
      csvt_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind          = rsp_kind;
         seen.row           = rsp_row;
         seen.col           = rsp_col;
         seen.byte_res      = rsp_byte_res;
         seen.blank_count   = rsp_blank_count;
         seen.blank_pattern = rsp_blank_pattern;
         seen.error_code    = rsp_error_code;
         seen.last          = rsp_last;
         if (expected_tokens.size() == 0) begin
            note_failure($sformatf("unexpected result %s", token_text(seen)));
         end else begin
            want = expected_tokens.pop_front();
            if (seen.kind !== want.kind || seen.row !== want.row || seen.col !== want.col ||
                seen.byte_res !== want.byte_res || seen.blank_count !== want.blank_count ||
                seen.blank_pattern !== want.blank_pattern ||
                seen.error_code !== want.error_code || seen.last !== want.last)
               note_failure($sformatf("expected %s, got %s", token_text(want),
                                      token_text(seen)));
         end
      end
   end

   // Stimulus and end of run
   initial begin
      scan_restart();

      // After reset, extremes of the byte, blanks, quoting, errors, end of input
      script_pinned(csvt_pkg::OP_END, 8'hA5, csvt_pkg::KIND_DONE, '0, '0, 8'h00, '0,
                    16'h0000, '0);
      script_pinned(csvt_pkg::OP_DATA, 8'h00, csvt_pkg::KIND_BYTE, '0, '0, 8'h00, '0,
                    16'h0000, '0);
      script_pinned(csvt_pkg::OP_DATA, 8'hFF, csvt_pkg::KIND_BYTE, '0, '0, 8'hFF, '0,
                    16'h0000, '0);
      script_pinned(csvt_pkg::OP_DATA, csvt_pkg::CH_COMMA, csvt_pkg::KIND_END, '0, '0,
                    8'h00, '0, 16'h0000, '0);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_TAB);
      script_pinned(csvt_pkg::OP_DATA, 8'h78, csvt_pkg::KIND_BYTE, '0, 10'd1, 8'h78, 5'd1,
                    16'h0001, '0);
      script_pinned(csvt_pkg::OP_DATA, csvt_pkg::CH_CR, csvt_pkg::KIND_END, '0, 10'd1,
                    8'h00, '0, 16'h0000, '0);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_LF);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_COMMA);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_TAB);
      script_pinned(csvt_pkg::OP_DATA, csvt_pkg::CH_LF, csvt_pkg::KIND_END, 16'd1, '0,
                    8'h00, '0, 16'h0000, '0);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_COMMA);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_SPACE);
      script_beat(csvt_pkg::OP_END, 8'h00);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
      script_beat(csvt_pkg::OP_DATA, 8'h71);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
      script_pinned(csvt_pkg::OP_DATA, 8'h71, csvt_pkg::KIND_ERR, '0, '0, 8'h00, '0,
                    16'h0000, csvt_pkg::ERR_AFTERQ);
      script_beat(csvt_pkg::OP_DATA, 8'h6B);
      script_pinned(csvt_pkg::OP_END, 8'hFF, csvt_pkg::KIND_DONE, '0, '0, 8'h00, '0,
                    16'h0000, '0);
      script_beat(csvt_pkg::OP_DATA, csvt_pkg::CH_QUOTE);
      script_beat(csvt_pkg::OP_END, 8'h5A);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         pin_armed    = script[i].pinned;
         pinned_token = script[i].want;
         send_beat(script[i].op, script[i].data);
      end
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         beats_sent = 0;
         if (ph == 0) begin
            // long receiver hold-off while the sender keeps offering bytes
            rsp_hold_cycles = 150;
            repeat (40) send_beat(csvt_pkg::OP_DATA, pick_text());
            send_beat(csvt_pkg::OP_END, 8'h00);
         end
         while (beats_sent < RANDOM_BEATS_PER_PHASE) send_file();
         wait_drained();
      end

      rsp_stall_pct = 0;
      repeat (10) @(posedge clock);
      if (expected_tokens.size() != 0)
         note_failure($sformatf("%0d expected results never arrived", expected_tokens.size()));
      if (failures == 0) $display("csv_stream_tokenizer_unit test passed");
      else $display("csv_stream_tokenizer_unit test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("csv_stream_tokenizer_unit test failed");
      $finish;
   end

endmodule
